/* rtl/core/hls_pkg.sv */
`default_nettype none
package hls_pkg;

   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_LF = 8'h0A;
   localparam logic [7:0] CH_SP = 8'h20;
   localparam logic [7:0] CH_HT = 8'h09;

   typedef enum logic [1:0] {
      KIND_BYTE  = 2'd0,
      KIND_LINE  = 2'd1,
      KIND_EMPTY = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] line_byte;
      logic       last;
   } result_type;

   // up to two results per input beat, count is 0..2
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } decode_type;

endpackage
`default_nettype wire

/* rtl/core/hls_if.sv */
`default_nettype none
interface hls_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       header_mode;

   modport source (output valid, output data_byte, output header_mode, input ready);
   modport sink   (input valid, input data_byte, input header_mode, output ready);
endinterface

interface hls_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] line_byte;
   logic       last;

   modport source (output valid, output kind, output line_byte, output last, input ready);
   modport sink   (input valid, input kind, input line_byte, input last, output ready);
endinterface
`default_nettype wire

/* rtl/core/hls_decoder.sv */
`default_nettype none
module hls_decoder (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               load,
   input  wire logic [7:0]         data_byte,
   input  wire logic               header_mode,
   input  wire logic               advance,
   output logic                    busy,
   output hls_pkg::decode_type     dec
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'd0,
      ST_MORE  = 3'd1,
      ST_LF    = 3'd2,
      ST_EMPTY = 3'd3,
      ST_FOUND = 3'd4
   } state_type;

   state_type  state_ff, state_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       mode_ff;

   logic       is_cr, is_lf, is_fold;
   logic       s_put;
   hls_pkg::kind_type s_kind;
   state_type  s_state;
   hls_pkg::result_type r0, r1;
   logic [1:0] n;

   assign is_cr   = (byte_ff == hls_pkg::CH_CR);
   assign is_lf   = (byte_ff == hls_pkg::CH_LF);
   assign is_fold = mode_ff && ((byte_ff == hls_pkg::CH_SP) || (byte_ff == hls_pkg::CH_HT));

   // first byte of a line
   always_comb begin
      if (is_cr) begin
         s_put   = 1'b0;
         s_kind  = hls_pkg::KIND_BYTE;
         s_state = ST_EMPTY;
      end else if (is_lf) begin
         s_put   = 1'b1;
         s_kind  = hls_pkg::KIND_EMPTY;
         s_state = ST_IDLE;
      end else begin
         s_put   = 1'b1;
         s_kind  = hls_pkg::KIND_BYTE;
         s_state = ST_MORE;
      end
   end

   always_comb begin
      n        = 2'd0;
      state_in = state_ff;
      r0       = '{kind: hls_pkg::KIND_BYTE, line_byte: byte_ff, last: 1'b0};
      r1       = '{kind: s_kind, line_byte: 8'd0, last: 1'b0};
      unique case (state_ff)
         ST_MORE: begin
            if (is_cr) begin
               state_in = ST_LF;
            end else if (is_lf) begin
               state_in = ST_FOUND;
            end else begin
               n        = 2'd1;
               state_in = ST_MORE;
            end
         end
         ST_LF: begin
            if (is_lf) begin
               state_in = ST_FOUND;
            end else if (!is_cr) begin
               n        = 2'd1;
               state_in = ST_MORE;
            end
         end
         ST_EMPTY: begin
            if (is_lf) begin
               n        = 2'd1;
               r0.kind  = hls_pkg::KIND_EMPTY;
               state_in = ST_IDLE;
            end else if (!is_cr) begin
               n        = 2'd1;
               state_in = ST_MORE;
            end
         end
         ST_FOUND: begin
            if (is_fold) begin
               n        = 2'd1;
               state_in = ST_MORE;
            end else if (!(mode_ff && is_cr)) begin
               // line confirmed, then this beat starts the next line
               r0.kind  = hls_pkg::KIND_LINE;
               n        = s_put ? 2'd2 : 2'd1;
               state_in = s_state;
               if (s_kind == hls_pkg::KIND_BYTE) begin
                  r1.line_byte = byte_ff;
               end
            end
         end
         default: begin
            n        = {1'b0, s_put};
            r0.kind  = s_kind;
            state_in = s_state;
         end
      endcase
      if (r0.kind != hls_pkg::KIND_BYTE) begin
         r0.line_byte = 8'd0;
      end
      r0.last = (n == 2'd1);
      r1.last = 1'b1;
   end

   assign valid_in  = load ? 1'b1 : (advance ? 1'b0 : valid_ff);
   assign busy      = valid_ff;
   assign dec.count = valid_ff ? n : 2'd0;
   assign dec.first  = r0;
   assign dec.second = r1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
      if (load) begin
         byte_ff <= data_byte;
         mode_ff <= header_mode;
      end
   end

endmodule
`default_nettype wire

/* rtl/core/hls_result_queue.sv */
`default_nettype none
module hls_result_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire hls_pkg::decode_type dec,
   output logic [2:0]               room,
   input  wire logic                pop,
   output logic                     out_valid,
   output hls_pkg::result_type      out_data
);

   hls_pkg::result_type entries_ff [4];
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [2:0] count_ff, count_in;
   logic [1:0] push_n;

   assign push_n    = push ? dec.count : 2'd0;
   assign room      = 3'd4 - count_ff;
   assign out_valid = (count_ff != 3'd0);
   assign out_data  = entries_ff[rd_ptr_ff];

   assign wr_ptr_in = wr_ptr_ff + push_n;
   assign rd_ptr_in = rd_ptr_ff + {1'b0, pop};
   assign count_in  = count_ff + {1'b0, push_n} - {2'b00, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= 2'd0;
         wr_ptr_ff <= 2'd0;
         count_ff  <= 3'd0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
      if (push_n != 2'd0) begin
         entries_ff[wr_ptr_ff] <= dec.first;
      end
      if (push_n == 2'd2) begin
         entries_ff[wr_ptr_ff + 2'd1] <= dec.second;
      end
   end

endmodule
`default_nettype wire

/* rtl/core/http_line_splitter.sv */
// HTTP line splitter. One byte beat enters per clock into an input register
// while the decoder is empty or can advance; the parse state machine decides
// that registered byte and, once the queue has room, pushes zero, one or two
// results (content byte, line complete, empty line) into a four-entry result
// queue feeding the rsp channel. Sustained rate is one byte per cycle while
// the consumer takes one result per cycle; a byte that confirms a line end and
// starts the next line yields two results and so costs one extra output beat,
// which the queue absorbs until it fills.
// The end of a line is reported only when the byte after the break arrives.
`default_nettype none
module http_line_splitter (
   input  wire logic     clock,
   input  wire logic     reset,
   hls_req_if.sink       req_if,
   hls_rsp_if.source     rsp_if
);

   hls_pkg::decode_type dec;
   hls_pkg::result_type out_data;
   logic [2:0] room;
   logic       busy;
   logic       advance;
   logic       load;
   logic       pop;
   logic       out_valid;

   assign advance      = busy && (room >= {1'b0, dec.count});
   assign req_if.ready = !busy || advance;
   assign load         = req_if.valid && req_if.ready;
   assign pop          = rsp_if.ready && out_valid;

   hls_decoder u_decoder (
      .clock       (clock),
      .reset       (reset),
      .load        (load),
      .data_byte   (req_if.data_byte),
      .header_mode (req_if.header_mode),
      .advance     (advance),
      .busy        (busy),
      .dec         (dec)
   );

   hls_result_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (advance),
      .dec       (dec),
      .room      (room),
      .pop       (pop),
      .out_valid (out_valid),
      .out_data  (out_data)
   );

   assign rsp_if.valid     = out_valid;
   assign rsp_if.kind      = out_data.kind;
   assign rsp_if.line_byte = out_data.line_byte;
   assign rsp_if.last      = out_data.last;

endmodule
`default_nettype wire

/* verif/http_line_splitter_tb.sv */
`timescale 1ns / 100ps
module http_line_splitter_tb;

   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 10;

   typedef enum logic [2:0] {
      LS_START       = 3'd0,
      LS_IN_LINE     = 3'd1,
      LS_CR_IN_LINE  = 3'd2,
      LS_CR_AT_START = 3'd3,
      LS_BREAK       = 3'd4
   } line_state_type;

   logic clock;
   logic reset;

   hls_req_if req_if();
   hls_rsp_if rsp_if();

   http_line_splitter u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   line_state_type       line_state;
   hls_pkg::result_type  pending_results[$];
   hls_pkg::result_type  step_results[$];
   int                   fault_count    = 0;
   int                   bytes_sent     = 0;
   int                   send_idle_pct  = 0;
   int                   recv_stall_pct = 0;
   int                   quiet_cycles   = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor
   function automatic void add_result(hls_pkg::kind_type k, logic [7:0] b);
      hls_pkg::result_type r;
      r.kind      = k;
      r.line_byte = (k == hls_pkg::KIND_BYTE) ? b : 8'h00;
      r.last      = 1'b0;
      step_results.push_back(r);
   endfunction

   function automatic void begin_line(logic [7:0] b);
      if (b == hls_pkg::CH_CR) begin
         line_state = LS_CR_AT_START;
      end else if (b == hls_pkg::CH_LF) begin
         add_result(hls_pkg::KIND_EMPTY, 8'h00);
         line_state = LS_START;
      end else begin
         add_result(hls_pkg::KIND_BYTE, b);
         line_state = LS_IN_LINE;
      end
   endfunction

   function automatic void split_byte(logic [7:0] b, logic hdr);
      case (line_state)
         LS_IN_LINE: begin
            if (b == hls_pkg::CH_CR) begin
               line_state = LS_CR_IN_LINE;
            end else if (b == hls_pkg::CH_LF) begin
               line_state = LS_BREAK;
            end else begin
               add_result(hls_pkg::KIND_BYTE, b);
            end
         end
         LS_CR_IN_LINE: begin
            if (b == hls_pkg::CH_LF) begin
               line_state = LS_BREAK;
            end else if (b != hls_pkg::CH_CR) begin
               add_result(hls_pkg::KIND_BYTE, b);
               line_state = LS_IN_LINE;
            end
         end
         LS_CR_AT_START: begin
            if (b == hls_pkg::CH_LF) begin
               add_result(hls_pkg::KIND_EMPTY, 8'h00);
               line_state = LS_START;
            end else if (b != hls_pkg::CH_CR) begin
               add_result(hls_pkg::KIND_BYTE, b);
               line_state = LS_IN_LINE;
            end
         end
         LS_BREAK: begin
            if (hdr && (b == hls_pkg::CH_SP || b == hls_pkg::CH_HT)) begin
               add_result(hls_pkg::KIND_BYTE, b);
               line_state = LS_IN_LINE;
            end else if (!(hdr && b == hls_pkg::CH_CR)) begin
               add_result(hls_pkg::KIND_LINE, 8'h00);
               begin_line(b);
            end
         end
         default: begin
            begin_line(b);
         end
      endcase
      if (step_results.size() > 0) begin
         step_results[step_results.size() - 1].last = 1'b1;
      end
      foreach (step_results[i]) begin
         pending_results.push_back(step_results[i]);
      end
      step_results.delete();
   endfunction

   // ---------------------------------------------------------------- drivers
   task automatic send_byte(input logic [7:0] b, input logic hdr);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.data_byte   <= b;
      req_if.header_mode <= hdr;
      do @(posedge clock); while (!req_if.ready);
      split_byte(b, hdr);
      bytes_sent++;
   endtask

   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // ---------------------------------------------------------------- checker
   always @(posedge clock) begin
      hls_pkg::result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_results.size() == 0) begin
            fault_count++;
            $display("%0t: unexpected beat: expected none, actual kind %0d byte %02h last %0d",
                     $time, rsp_if.kind, rsp_if.line_byte, rsp_if.last);
         end else begin
            want = pending_results.pop_front();
            if (rsp_if.kind !== want.kind) begin
               fault_count++;
               $display("%0t: kind mismatch: expected %0d, actual %0d",
                        $time, want.kind, rsp_if.kind);
            end
            if (rsp_if.line_byte !== want.line_byte) begin
               fault_count++;
               $display("%0t: line_byte mismatch: expected %02h, actual %02h",
                        $time, want.line_byte, rsp_if.line_byte);
            end
            if (rsp_if.last !== want.last) begin
               fault_count++;
               $display("%0t: last mismatch: expected %0d, actual %0d",
                        $time, want.last, rsp_if.last);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- tests
   task automatic test_line_breaks();
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(hls_pkg::CH_CR, 1'b0);
      send_byte(hls_pkg::CH_CR, 1'b0);       // repeated CR inside a line
      send_byte(hls_pkg::CH_LF, 1'b0);
      send_byte(8'h78, 1'b0);                // confirms line, starts the next
      send_byte(hls_pkg::CH_CR, 1'b0);
      send_byte(8'h79, 1'b0);                // stray CR dropped
      send_byte(hls_pkg::CH_LF, 1'b0);
      send_byte(hls_pkg::CH_LF, 1'b0);       // line complete then empty line
      send_byte(hls_pkg::CH_CR, 1'b0);
      send_byte(hls_pkg::CH_CR, 1'b0);
      send_byte(8'h7A, 1'b0);                // stray CR at line start
      send_byte(hls_pkg::CH_LF, 1'b0);
      send_byte(hls_pkg::CH_CR, 1'b0);       // standard mode: CR confirms the break
      send_byte(hls_pkg::CH_LF, 1'b0);
   endtask

   task automatic test_header_folding();
      send_byte(8'h68, 1'b1);
      send_byte(hls_pkg::CH_LF, 1'b1);
      send_byte(hls_pkg::CH_SP, 1'b1);       // fold on SP
      send_byte(hls_pkg::CH_CR, 1'b1);
      send_byte(hls_pkg::CH_LF, 1'b1);
      send_byte(hls_pkg::CH_HT, 1'b1);       // fold on HT
      send_byte(hls_pkg::CH_LF, 1'b1);
      send_byte(hls_pkg::CH_CR, 1'b1);       // CR after break held in header mode
      send_byte(8'h6B, 1'b1);
      send_byte(hls_pkg::CH_LF, 1'b1);
      send_byte(hls_pkg::CH_SP, 1'b0);       // no fold once mode drops
   endtask

   function automatic logic [7:0] noise_byte();
      case ($urandom_range(0, 5))
         0:       return hls_pkg::CH_CR;
         1:       return hls_pkg::CH_LF;
         2:       return hls_pkg::CH_SP;
         3:       return hls_pkg::CH_HT;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_random_line();
      logic hdr;
      hdr = 1'($urandom_range(0, 1));
      repeat ($urandom_range(0, 6)) send_byte(8'($urandom_range(0, 255)), hdr);
      case ($urandom_range(0, 3))
         0: begin
            send_byte(hls_pkg::CH_CR, hdr);
            send_byte(hls_pkg::CH_LF, hdr);
         end
         1: begin
            send_byte(hls_pkg::CH_LF, hdr);
         end
         2: begin
            send_byte(hls_pkg::CH_CR, hdr);
            send_byte(hls_pkg::CH_CR, hdr);
            send_byte(hls_pkg::CH_LF, hdr);
         end
         default: begin
            send_byte(hls_pkg::CH_CR, hdr);
            send_byte(hls_pkg::CH_LF, hdr);
            if (hdr) begin
               send_byte(hls_pkg::CH_CR, hdr);
            end
         end
      endcase
      if (hdr && $urandom_range(0, 2) == 0) begin
         send_byte(($urandom_range(0, 1) != 0) ? hls_pkg::CH_SP : hls_pkg::CH_HT, hdr);
      end
   endtask

   task automatic test_random_stream(input int idle_pct, input int stall_pct, input int count);
      int target;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      target         = bytes_sent + count;
      while (bytes_sent < target) begin
         if ($urandom_range(0, 9) < 7) begin
            send_random_line();
         end else begin
            repeat ($urandom_range(1, 4)) send_byte(noise_byte(), 1'($urandom_range(0, 1)));
         end
      end
   endtask

   initial begin
      reset              = 1'b1;
      req_if.valid       = 1'b0;
      req_if.data_byte   = 8'h00;
      req_if.header_mode = 1'b0;
      line_state         = LS_START;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_line_breaks();
      test_header_folding();
      test_random_stream(0, 0, 225);
      test_random_stream(84, 0, 225);
      test_random_stream(0, 84, 225);
      test_random_stream(35, 35, 225);

      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fault_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

/* http_line_splitter.f */
rtl/core/hls_pkg.sv
rtl/core/hls_if.sv
rtl/core/hls_decoder.sv
rtl/core/hls_result_queue.sv
rtl/core/http_line_splitter.sv
verif/http_line_splitter_tb.sv
